// ===== rtl/move_command_line_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the move command line parser
// Concurrent checks, clocked and disabled in reset, same-cycle or next-cycle.
// ----------------------------------------------------------------------------
`ifndef MOVE_COMMAND_LINE_PARSER_ASSERT_SVH
`define MOVE_COMMAND_LINE_PARSER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define MCLP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mclp: same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define MCLP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mclp: next-cycle check failed");

`endif

// ===== rtl/mclp_pkg.sv =====
// ----------------------------------------------------------------------------
// mclp_pkg
// Types, character codes and helper functions of the move command line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mclp_pkg;

    localparam logic [7:0] CH_NUL     = 8'd0;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_PLUS    = 8'd43;
    localparam logic [7:0] CH_MINUS   = 8'd45;

    localparam logic [7:0] PREFIX_TEXT [5] = '{8'd109, 8'd111, 8'd118, 8'd101, 8'd32};

    localparam logic [14:0] MAG_MAX = 15'h7FFF;

    localparam logic [15:0] MOVE_GAIN_RESET = 16'd459;
    localparam logic [15:0] TURN_GAIN_RESET = 16'd9830;

    localparam logic REG_MOVE_GAIN = 1'b0;
    localparam logic REG_TURN_GAIN = 1'b1;

    typedef enum logic [12:0] {
        PH_PREFIX0     = 13'b0000000000001,
        PH_PREFIX1     = 13'b0000000000010,
        PH_PREFIX2     = 13'b0000000000100,
        PH_PREFIX3     = 13'b0000000001000,
        PH_PREFIX4     = 13'b0000000010000,
        PH_SPACE_TURN  = 13'b0000000100000,
        PH_TURN_SIGN   = 13'b0000001000000,
        PH_TURN_DIGITS = 13'b0000010000000,
        PH_SPACE_MOVE  = 13'b0000100000000,
        PH_MOVE_SIGN   = 13'b0001000000000,
        PH_MOVE_DIGITS = 13'b0010000000000,
        PH_DONE        = 13'b0100000000000,
        PH_REJECT      = 13'b1000000000000
    } phase_t;

    typedef struct packed {
        logic        emit;
        logic        turn_neg;
        logic [14:0] turn_mag;
        logic        move_neg;
        logic [14:0] move_mag;
    } parse_result_t;

    typedef struct packed {
        logic signed [15:0] turn_value;
        logic signed [15:0] move_value;
        logic signed [31:0] move_command;
        logic signed [31:0] turn_command;
    } out_beat_t;

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'd32) || (c == 8'd9) || (c == 8'd11) || (c == 8'd12) || (c == 8'd13);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'd48) && (c <= 8'd57);
    endfunction

    function automatic logic [14:0] add_digit(logic [14:0] mag, logic [7:0] c);
        logic [18:0] v;
        v = {4'd0, mag} * 19'd10 + {15'd0, c[3:0]};
        return (v > {4'd0, MAG_MAX}) ? MAG_MAX : v[14:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mclp_parser.sv =====
// ----------------------------------------------------------------------------
// mclp_parser
// Byte-wise line scanner: prefix match, two signed decimal fields, line limit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "move_command_line_parser_assert.svh"

module mclp_parser #(
    parameter int LINE_LIMIT = 64
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   accept,
    input  wire logic [7:0]             rx_byte,
    output mclp_pkg::parse_result_t     result
);

    localparam int POS_W = $clog2(LINE_LIMIT);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_LIMIT - 1);

    mclp_pkg::phase_t phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             dead_reg, dead_next;
    logic             turn_neg_reg, turn_neg_next;
    logic             move_neg_reg, move_neg_next;
    logic [14:0]      turn_mag_reg, turn_mag_next;
    logic [14:0]      move_mag_reg, move_mag_next;

    always_comb begin
        logic sign;
        logic neg;
        logic space;
        logic digit;

        sign  = (rx_byte == mclp_pkg::CH_PLUS) || (rx_byte == mclp_pkg::CH_MINUS);
        neg   = (rx_byte == mclp_pkg::CH_MINUS);
        space = mclp_pkg::is_space(rx_byte);
        digit = mclp_pkg::is_digit(rx_byte);

        phase_next    = phase_reg;
        pos_next      = pos_reg;
        dead_next     = dead_reg;
        turn_neg_next = turn_neg_reg;
        move_neg_next = move_neg_reg;
        turn_mag_next = turn_mag_reg;
        move_mag_next = move_mag_reg;

        result.emit     = 1'b0;
        result.turn_neg = turn_neg_reg;
        result.turn_mag = turn_mag_reg;
        result.move_neg = move_neg_reg;
        result.move_mag = move_mag_reg;

        if (accept) begin
            if (rx_byte == mclp_pkg::CH_NEWLINE) begin
                result.emit   = (phase_reg == mclp_pkg::PH_MOVE_DIGITS) ||
                                (phase_reg == mclp_pkg::PH_DONE);
                phase_next    = mclp_pkg::PH_PREFIX0;
                pos_next      = '0;
                dead_next     = 1'b0;
                turn_neg_next = 1'b0;
                move_neg_next = 1'b0;
                turn_mag_next = '0;
                move_mag_next = '0;
            end else if (pos_reg < POS_LAST) begin
                pos_next = pos_reg + 1'b1;
                if (!dead_reg) begin
                    if (rx_byte == mclp_pkg::CH_NUL) begin
                        dead_next = 1'b1;
                    end else begin
                        unique case (phase_reg)
                            mclp_pkg::PH_PREFIX0: begin
                                phase_next = (rx_byte == mclp_pkg::PREFIX_TEXT[0]) ?
                                             mclp_pkg::PH_PREFIX1 : mclp_pkg::PH_REJECT;
                            end
                            mclp_pkg::PH_PREFIX1: begin
                                phase_next = (rx_byte == mclp_pkg::PREFIX_TEXT[1]) ?
                                             mclp_pkg::PH_PREFIX2 : mclp_pkg::PH_REJECT;
                            end
                            mclp_pkg::PH_PREFIX2: begin
                                phase_next = (rx_byte == mclp_pkg::PREFIX_TEXT[2]) ?
                                             mclp_pkg::PH_PREFIX3 : mclp_pkg::PH_REJECT;
                            end
                            mclp_pkg::PH_PREFIX3: begin
                                phase_next = (rx_byte == mclp_pkg::PREFIX_TEXT[3]) ?
                                             mclp_pkg::PH_PREFIX4 : mclp_pkg::PH_REJECT;
                            end
                            mclp_pkg::PH_PREFIX4: begin
                                phase_next = (rx_byte == mclp_pkg::PREFIX_TEXT[4]) ?
                                             mclp_pkg::PH_SPACE_TURN : mclp_pkg::PH_REJECT;
                            end
                            mclp_pkg::PH_SPACE_TURN: begin
                                if (space) begin
                                    phase_next = phase_reg;
                                end else if (sign) begin
                                    turn_neg_next = neg;
                                    phase_next    = mclp_pkg::PH_TURN_SIGN;
                                end else if (digit) begin
                                    turn_mag_next = mclp_pkg::add_digit(turn_mag_reg, rx_byte);
                                    phase_next    = mclp_pkg::PH_TURN_DIGITS;
                                end else begin
                                    phase_next = mclp_pkg::PH_REJECT;
                                end
                            end
                            mclp_pkg::PH_TURN_SIGN: begin
                                if (digit) begin
                                    turn_mag_next = mclp_pkg::add_digit(turn_mag_reg, rx_byte);
                                    phase_next    = mclp_pkg::PH_TURN_DIGITS;
                                end else begin
                                    phase_next = mclp_pkg::PH_REJECT;
                                end
                            end
                            mclp_pkg::PH_TURN_DIGITS: begin
                                if (digit) begin
                                    turn_mag_next = mclp_pkg::add_digit(turn_mag_reg, rx_byte);
                                end else if (space) begin
                                    phase_next = mclp_pkg::PH_SPACE_MOVE;
                                end else if (sign) begin
                                    move_neg_next = neg;
                                    phase_next    = mclp_pkg::PH_MOVE_SIGN;
                                end else begin
                                    phase_next = mclp_pkg::PH_REJECT;
                                end
                            end
                            mclp_pkg::PH_SPACE_MOVE: begin
                                if (space) begin
                                    phase_next = phase_reg;
                                end else if (sign) begin
                                    move_neg_next = neg;
                                    phase_next    = mclp_pkg::PH_MOVE_SIGN;
                                end else if (digit) begin
                                    move_mag_next = mclp_pkg::add_digit(move_mag_reg, rx_byte);
                                    phase_next    = mclp_pkg::PH_MOVE_DIGITS;
                                end else begin
                                    phase_next = mclp_pkg::PH_REJECT;
                                end
                            end
                            mclp_pkg::PH_MOVE_SIGN: begin
                                if (digit) begin
                                    move_mag_next = mclp_pkg::add_digit(move_mag_reg, rx_byte);
                                    phase_next    = mclp_pkg::PH_MOVE_DIGITS;
                                end else begin
                                    phase_next = mclp_pkg::PH_REJECT;
                                end
                            end
                            mclp_pkg::PH_MOVE_DIGITS: begin
                                if (digit) begin
                                    move_mag_next = mclp_pkg::add_digit(move_mag_reg, rx_byte);
                                end else begin
                                    phase_next = mclp_pkg::PH_DONE;
                                end
                            end
                            default: begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= mclp_pkg::PH_PREFIX0;
            pos_reg      <= '0;
            dead_reg     <= 1'b0;
            turn_neg_reg <= 1'b0;
            move_neg_reg <= 1'b0;
            turn_mag_reg <= '0;
            move_mag_reg <= '0;
        end else begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            dead_reg     <= dead_next;
            turn_neg_reg <= turn_neg_next;
            move_neg_reg <= move_neg_next;
            turn_mag_reg <= turn_mag_next;
            move_mag_reg <= move_mag_next;
        end
    end

    `MCLP_ASSERT_NEXT(a_newline_clears, aclk, aresetn,
        accept && (rx_byte == mclp_pkg::CH_NEWLINE),
        (phase_reg == mclp_pkg::PH_PREFIX0) && (pos_reg == '0) && !dead_reg)
    `MCLP_ASSERT_NOW(a_pos_bound, aclk, aresetn, 1'b1, pos_reg <= POS_LAST)

endmodule

`default_nettype wire

// ===== rtl/move_command_line_parser.sv =====
// ----------------------------------------------------------------------------
// move_command_line_parser
// Parses "move <turn> <move>" text lines into raw values and Q16.16 commands.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one received byte per beat; newline ends a line.
//   m_* channel gives one registered beat per valid line, after its newline: both
//   saturated integers, move_value * move_gain and -turn_value * turn_gain.
//   cfg_* channel, always ready, writes move_gain (index 0) or turn_gain (index 1);
//   the user writes it only while no line result is pending; the block does not enforce it.
// Timing:
//   One byte per cycle while s_ready is high. A line's result is registered in
//   the output register, or the skid entry if stalled. Per byte, the path is the
//   line-state registers, one 15x16 multiply per command, and the output register.
// Stall:
//   A two-entry output (register plus skid) keeps input flowing while one
//   result waits; s_ready drops only when both entries hold results.
// Reset:
//   aresetn low clears the line state, drops both output entries and loads
//   the default gains.
// ----------------------------------------------------------------------------
`default_nettype none
`include "move_command_line_parser_assert.svh"

module move_command_line_parser #(
    parameter int LINE_LIMIT = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_rx_byte,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_turn_value,
    output logic signed [15:0]      m_move_value,
    output logic signed [31:0]      m_move_command,
    output logic signed [31:0]      m_turn_command,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [15:0]        cfg_data
);

    logic [15:0] move_gain_reg;
    logic [15:0] turn_gain_reg;

    logic                    s_accept;
    mclp_pkg::parse_result_t result;
    mclp_pkg::out_beat_t     beat;
    logic [30:0]             move_prod;
    logic [30:0]             turn_prod;

    mclp_pkg::out_beat_t out_reg, out_next;
    mclp_pkg::out_beat_t skid_reg, skid_next;
    logic                out_valid_reg, out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    logic                load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_gain_reg <= mclp_pkg::MOVE_GAIN_RESET;
            turn_gain_reg <= mclp_pkg::TURN_GAIN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                mclp_pkg::REG_MOVE_GAIN: move_gain_reg <= cfg_data;
                mclp_pkg::REG_TURN_GAIN: turn_gain_reg <= cfg_data;
                default:                 move_gain_reg <= move_gain_reg;
            endcase
        end
    end

    assign s_ready  = !skid_valid_reg;
    assign s_accept = s_valid && s_ready;

    mclp_parser #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .rx_byte (s_rx_byte),
        .result  (result)
    );

    assign move_prod = 31'(result.move_mag) * 31'(move_gain_reg);
    assign turn_prod = 31'(result.turn_mag) * 31'(turn_gain_reg);

    always_comb begin
        beat.turn_value   = result.turn_neg ? -$signed({1'b0, result.turn_mag})
                                            :  $signed({1'b0, result.turn_mag});
        beat.move_value   = result.move_neg ? -$signed({1'b0, result.move_mag})
                                            :  $signed({1'b0, result.move_mag});
        beat.move_command = result.move_neg ? -$signed({1'b0, move_prod})
                                            :  $signed({1'b0, move_prod});
        beat.turn_command = result.turn_neg ?  $signed({1'b0, turn_prod})
                                            : -$signed({1'b0, turn_prod});
    end

    assign load = s_accept && result.emit;

    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        priority if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = beat;
                out_valid_next = load;
            end
        end else if (load) begin
            skid_next       = beat;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_turn_value   = out_reg.turn_value;
    assign m_move_value   = out_reg.move_value;
    assign m_move_command = out_reg.move_command;
    assign m_turn_command = out_reg.turn_command;

    `MCLP_ASSERT_NOW(a_skid_needs_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `MCLP_ASSERT_NEXT(a_stalled_load_to_skid, aclk, aresetn,
        load && out_valid_reg && !m_ready, skid_valid_reg && out_valid_reg)

endmodule

`default_nettype wire
